>>> design/dhglcd_pkg.sv
package dhglcd_pkg;

    // fixed geometry of one display half
    localparam int HALF_COLUMNS = 64;
    localparam int COL_W        = 6;
    localparam int PAGE_W       = 3;
    localparam int LINE_W       = 6;

    // command byte ranges, each constant is the first code of its range
    localparam logic [7:0] CMD_DISPLAY_BASE = 8'd62;
    localparam logic [7:0] CMD_COLUMN_BASE  = 8'd64;
    localparam logic [7:0] CMD_UNUSED_BASE  = 8'd128;
    localparam logic [7:0] CMD_PAGE_BASE    = 8'd184;
    localparam logic [7:0] CMD_START_BASE   = 8'd192;

    // access direction
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // one bus access
    typedef struct packed {
        logic       mode;
        logic       reset_low;
        logic       select_one;
        logic       select_two;
        logic       is_data;
        logic [7:0] write_byte;
    } dhglcd_in_t;

    // result of one bus access
    typedef struct packed {
        logic [7:0]        read_byte;
        logic              bus_driven;
        logic              dropped;
        logic              display_enabled;
        logic [LINE_W-1:0] first_line;
    } dhglcd_out_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic finish;
    } dhglcd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } dhglcd_status_t;

endpackage

>>> design/dhglcd_ram.sv
module dhglcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                     wdata,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

>>> design/dhglcd_ctrl.sv
module dhglcd_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  logic                    out_stall,
    output dhglcd_pkg::dhglcd_cmd_t cmd,
    input  dhglcd_pkg::dhglcd_status_t status
);

    import dhglcd_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_finish;

    // output register is free when empty or being taken this cycle
    assign can_finish = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (can_finish)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> design/dhglcd_dp.sv
module dhglcd_dp #(
    parameter int PAGE_COUNT = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dhglcd_pkg::dhglcd_in_t     in_data,
    output dhglcd_pkg::dhglcd_out_t    out_data,
    input  logic                       cfg_we,
    input  logic                       cfg_data,
    input  dhglcd_pkg::dhglcd_cmd_t    cmd,
    output dhglcd_pkg::dhglcd_status_t status
);

    import dhglcd_pkg::*;

    localparam int DEPTH = PAGE_COUNT * HALF_COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0]   CLEAR_LAST = AW'(DEPTH - 1);
    localparam logic [PAGE_W:0] PAGE_LIMIT = (PAGE_W + 1)'(PAGE_COUNT);

    // configuration and pointer state
    logic                select_active_low_reg;
    logic [PAGE_W-1:0]   page_left_reg;
    logic [PAGE_W-1:0]   page_left_next;
    logic [COL_W-1:0]    column_left_reg;
    logic [COL_W-1:0]    column_left_next;
    logic [PAGE_W-1:0]   page_right_reg;
    logic [PAGE_W-1:0]   page_right_next;
    logic [COL_W-1:0]    column_right_reg;
    logic [COL_W-1:0]    column_right_next;
    logic [LINE_W-1:0]   start_line_reg;
    logic [LINE_W-1:0]   start_line_next;
    logic                display_on_reg;
    logic                display_on_next;
    logic [AW-1:0]       clr_cnt_reg;

    // captured access
    dhglcd_in_t          item_reg;
    logic                sel_left_reg;
    logic                sel_right_reg;
    dhglcd_out_t         out_reg;
    dhglcd_out_t         out_next;

    // ram side
    logic                page_left_ok;
    logic                page_right_ok;
    logic                wr_left;
    logic                wr_right;
    logic                ram_we_left;
    logic                ram_we_right;
    logic [AW-1:0]       addr_left;
    logic [AW-1:0]       addr_right;
    logic [7:0]          ram_wdata;
    logic [7:0]          rd_left;
    logic [7:0]          rd_right;
    logic [PAGE_W+COL_W-1:0] ptr_left;
    logic [PAGE_W+COL_W-1:0] ptr_right;

    // effective selects of the incoming access
    logic                in_sel_two;
    logic                in_left;
    logic                in_right;

    // no half selected defaults to the right half, then optional inversion
    assign in_sel_two = in_data.select_two | ~(in_data.select_one | in_data.select_two);
    assign in_left    = in_data.select_one ^ select_active_low_reg;
    assign in_right   = in_sel_two ^ select_active_low_reg;

    // ram addresses follow the pointers, or the sweep counter while clearing
    assign ptr_left   = {page_left_reg, column_left_reg};
    assign ptr_right  = {page_right_reg, column_right_reg};
    assign addr_left  = cmd.clear ? clr_cnt_reg : ptr_left[AW-1:0];
    assign addr_right = cmd.clear ? clr_cnt_reg : ptr_right[AW-1:0];
    assign ram_wdata  = cmd.clear ? 8'd0 : item_reg.write_byte;
    assign ram_we_left  = cmd.clear | (cmd.finish & wr_left);
    assign ram_we_right = cmd.clear | (cmd.finish & wr_right);

    assign page_left_ok  = ({1'b0, page_left_reg} < PAGE_LIMIT);
    assign page_right_ok = ({1'b0, page_right_reg} < PAGE_LIMIT);

    assign status.clear_last = (clr_cnt_reg == CLEAR_LAST);

    dhglcd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram_left (
        .clk   (clk),
        .we    (ram_we_left),
        .re    (cmd.capture),
        .addr  (addr_left),
        .wdata (ram_wdata),
        .rdata (rd_left)
    );

    dhglcd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram_right (
        .clk   (clk),
        .we    (ram_we_right),
        .re    (cmd.capture),
        .addr  (addr_right),
        .wdata (ram_wdata),
        .rdata (rd_right)
    );

    // execute the captured access; a low reset pin clears the pointers first
    always_comb
    begin
        page_left_next    = item_reg.reset_low ? '0 : page_left_reg;
        column_left_next  = item_reg.reset_low ? '0 : column_left_reg;
        page_right_next   = item_reg.reset_low ? '0 : page_right_reg;
        column_right_next = item_reg.reset_low ? '0 : column_right_reg;
        start_line_next   = item_reg.reset_low ? '0 : start_line_reg;
        display_on_next   = item_reg.reset_low ? 1'b0 : display_on_reg;
        wr_left           = 1'b0;
        wr_right          = 1'b0;
        out_next          = '0;

        if (item_reg.is_data)
        begin
            // data access, ignored while the reset flag is set
            if (!item_reg.reset_low)
            begin
                if (item_reg.mode == MODE_READ)
                begin
                    if (sel_right_reg)
                    begin
                        out_next.read_byte = page_right_ok ? rd_right : 8'd0;
                    end
                    else if (sel_left_reg)
                    begin
                        out_next.read_byte = page_left_ok ? rd_left : 8'd0;
                    end
                end
                else
                begin
                    if (sel_left_reg)
                    begin
                        wr_left          = page_left_ok;
                        column_left_next = column_left_reg + COL_W'(1);
                    end
                    if (sel_right_reg)
                    begin
                        wr_right          = page_right_ok;
                        column_right_next = column_right_reg + COL_W'(1);
                    end
                end
            end
        end
        else if (item_reg.mode == MODE_READ)
        begin
            // status: bit4 reset flag, bit5 display off
            out_next.read_byte[4] = item_reg.reset_low;
            out_next.read_byte[5] = ~display_on_next;
        end
        else
        begin
            // command decode by byte range
            priority if (item_reg.write_byte < CMD_DISPLAY_BASE)
            begin
                display_on_next = display_on_next;
            end
            else if (item_reg.write_byte < CMD_COLUMN_BASE)
            begin
                display_on_next = item_reg.write_byte[0];
            end
            else if (item_reg.write_byte < CMD_UNUSED_BASE)
            begin
                if (sel_left_reg)
                begin
                    column_left_next = item_reg.write_byte[COL_W-1:0];
                end
                if (sel_right_reg)
                begin
                    column_right_next = item_reg.write_byte[COL_W-1:0];
                end
            end
            else if (item_reg.write_byte < CMD_PAGE_BASE)
            begin
                display_on_next = display_on_next;
            end
            else if (item_reg.write_byte < CMD_START_BASE)
            begin
                if (sel_left_reg)
                begin
                    page_left_next = item_reg.write_byte[PAGE_W-1:0];
                end
                if (sel_right_reg)
                begin
                    page_right_next = item_reg.write_byte[PAGE_W-1:0];
                end
            end
            else
            begin
                start_line_next = item_reg.write_byte[LINE_W-1:0];
            end
        end

        out_next.bus_driven      = item_reg.mode;
        out_next.dropped         = item_reg.is_data & item_reg.reset_low;
        out_next.display_enabled = display_on_next;
        out_next.first_line      = start_line_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_active_low_reg <= 1'b0;
            page_left_reg         <= '0;
            column_left_reg       <= '0;
            page_right_reg        <= '0;
            column_right_reg      <= '0;
            start_line_reg        <= '0;
            display_on_reg        <= 1'b0;
            clr_cnt_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                select_active_low_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.finish)
            begin
                page_left_reg    <= page_left_next;
                column_left_reg  <= column_left_next;
                page_right_reg   <= page_right_next;
                column_right_reg <= column_right_next;
                start_line_reg   <= start_line_next;
                display_on_reg   <= display_on_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg      <= in_data;
            sel_left_reg  <= in_left;
            sel_right_reg <= in_right;
        end
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

>>> design/dual_half_glcd_bus_controller.sv
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   in_data   (dhglcd_in_t)
// out       output     out_valid / out_stall out_data  (dhglcd_out_t)
// cfg       input      cfg_valid / cfg_ready cfg_data  (select_active_low)
//
// each access is captured with its ram read, then executed with its ram write
// a new access is taken in the cycle after the previous result is loaded into the
// output register; that register waits out a stalled output for one access
// after reset a clearing pass zeroes all PAGE_COUNT*64 entries of both half rams
// (512 at the default), with in_stall high; cfg writes are taken throughout
module dual_half_glcd_bus_controller #(
    parameter int PAGE_COUNT = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  dhglcd_pkg::dhglcd_in_t  in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output dhglcd_pkg::dhglcd_out_t out_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_data
);

    import dhglcd_pkg::*;

    dhglcd_cmd_t    cmd;
    dhglcd_status_t status;

    // register write is always taken
    assign cfg_ready = 1'b1;

    dhglcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    dhglcd_dp #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .out_data (out_data),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
